### rtl/core/vstg_pkg.sv
// Package: shared constants, command/status structs and glyph slot folding.
`default_nettype none

package vstg_pkg;

   localparam int MAX_POINTS   = 16;
   localparam int GLYPH_COUNT  = 95;
   localparam int SCALE_STEP   = 21;
   localparam int POS_SCALE    = 128;
   localparam int RESULT_LIMIT = 15;

   localparam int POS_SHIFT   = $clog2(POS_SCALE);
   localparam int SLOT_W      = $clog2(GLYPH_COUNT);
   localparam int IDX_W       = $clog2(MAX_POINTS);
   localparam int CNT_W       = IDX_W + 1;
   localparam int POINT_DEPTH = GLYPH_COUNT * MAX_POINTS;
   localparam int PADDR_W     = SLOT_W + IDX_W;
   localparam int SCALE_W     = 13;
   localparam int PROD_W      = 5 + SCALE_W + 1;
   localparam int ADVP_W      = 4 + SCALE_W;
   localparam int SEG_W       = $clog2(RESULT_LIMIT + 1);

   localparam logic [1:0] MODE_POINT  = 2'd0;
   localparam logic [1:0] MODE_HEADER = 2'd1;
   localparam logic [1:0] MODE_DRAW   = 2'd2;

   localparam logic [7:0] FIRST_CODE  = 8'h20;
   localparam logic [7:0] LAST_CODE   = 8'h7E;
   localparam logic [7:0] LOWER_A     = 8'h61;
   localparam logic [7:0] LOWER_Z     = 8'h7A;
   localparam logic [7:0] CASE_OFFSET = 8'h20;
   localparam logic [7:0] LOAD_LAST   = 8'(int'(FIRST_CODE) + GLYPH_COUNT - 1);

   localparam logic [9:0] PEN_UP_CODE = 10'h3FF;  // x = -1, y = -1

   typedef struct packed {
      logic load_point;
      logic load_header;
      logic start_draw;
      logic hdr_read;
      logic hdr_take;
      logic pt_read;
      logic pt_mul;
      logic pt_step;
      logic flush;
   } vstg_cmd_type;

   typedef struct packed {
      logic count_zero;
      logic last_point;
      logic step_stall;
      logic flush_stall;
   } vstg_stat_type;

   // Draw code to glyph slot: fold lower case, map unprintables to space.
   function automatic logic [SLOT_W-1:0] fold_slot(input logic [7:0] code);
      logic [7:0] c;
      c = code;
      if (c >= LOWER_A && c <= LOWER_Z) c = c - CASE_OFFSET;
      if (c < FIRST_CODE || c > LAST_CODE) c = FIRST_CODE;
      c = c - FIRST_CODE;
      if (int'(c) >= GLYPH_COUNT) c = 8'd0;
      return SLOT_W'(c);
   endfunction

endpackage

`default_nettype wire

### rtl/core/vstg_ctrl.sv
// Controller: sequences loads, header fetch, point walk and final flush.
`default_nettype none

module vstg_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   input  wire logic [1:0]             req_mode,
   output logic                        req_ready,
   output vstg_pkg::vstg_cmd_type      cmd,
   input  wire vstg_pkg::vstg_stat_type stat
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_HDR_RD,
      ST_HDR_TAKE,
      ST_PT_RD,
      ST_PT_MUL,
      ST_PT_ADD,
      ST_FLUSH
   } state_type;

   state_type state_ff, state_in;
   logic      accept;
   logic      is_point, is_header, is_draw;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   always_comb begin
      is_point  = 1'b0;
      is_header = 1'b0;
      is_draw   = 1'b0;
      unique case (req_mode)
         vstg_pkg::MODE_POINT:  is_point  = 1'b1;
         vstg_pkg::MODE_HEADER: is_header = 1'b1;
         vstg_pkg::MODE_DRAW:   is_draw   = 1'b1;
         default: ;  // unused mode: no effect
      endcase
   end

   always_comb begin
      cmd             = '0;
      cmd.load_point  = accept && is_point;
      cmd.load_header = accept && is_header;
      cmd.start_draw  = accept && is_draw;
      cmd.hdr_read    = (state_ff == ST_HDR_RD);
      cmd.hdr_take    = (state_ff == ST_HDR_TAKE);
      cmd.pt_read     = (state_ff == ST_PT_RD);
      cmd.pt_mul      = (state_ff == ST_PT_MUL);
      cmd.pt_step     = (state_ff == ST_PT_ADD) && !stat.step_stall;
      cmd.flush       = (state_ff == ST_FLUSH) && !stat.flush_stall;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:     if (cmd.start_draw) state_in = ST_HDR_RD;
         ST_HDR_RD:   state_in = ST_HDR_TAKE;
         ST_HDR_TAKE: state_in = stat.count_zero ? ST_FLUSH : ST_PT_RD;
         ST_PT_RD:    state_in = ST_PT_MUL;
         ST_PT_MUL:   state_in = ST_PT_ADD;
         ST_PT_ADD: begin
            if (!stat.step_stall) state_in = stat.last_point ? ST_FLUSH : ST_PT_RD;
         end
         ST_FLUSH:    if (!stat.flush_stall) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

### rtl/core/vstg_dp.sv
// Datapath: glyph stores, string latches, point scaling, segment hold and output register.
`default_nettype none

module vstg_dp (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire vstg_pkg::vstg_cmd_type   cmd,
   output vstg_pkg::vstg_stat_type       stat,
   input  wire logic                     req_new_string,
   input  wire logic signed [7:0]        req_origin_x,
   input  wire logic signed [7:0]        req_origin_y,
   input  wire logic [7:0]               req_size,
   input  wire logic [7:0]               req_brightness,
   input  wire logic [7:0]               req_char_code,
   input  wire logic [3:0]               req_point_index,
   input  wire logic signed [4:0]        req_point_x,
   input  wire logic signed [4:0]        req_point_y,
   input  wire logic [4:0]               req_glyph_points,
   input  wire logic [3:0]               req_glyph_advance,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic signed [31:0]            rsp_start_x,
   output logic signed [31:0]            rsp_start_y,
   output logic signed [31:0]            rsp_end_x,
   output logic signed [31:0]            rsp_end_y,
   output logic [7:0]                    rsp_beam_level,
   output logic                          rsp_last_segment
);

   localparam int SLOT_W  = vstg_pkg::SLOT_W;
   localparam int IDX_W   = vstg_pkg::IDX_W;
   localparam int CNT_W   = vstg_pkg::CNT_W;
   localparam int PROD_W  = vstg_pkg::PROD_W;
   localparam int SCALE_W = vstg_pkg::SCALE_W;
   localparam int ADVP_W  = vstg_pkg::ADVP_W;
   localparam int SEG_W   = vstg_pkg::SEG_W;

   // glyph stores, no reset
   logic [9:0] point_mem [0:vstg_pkg::POINT_DEPTH-1];
   logic [8:0] header_mem [0:vstg_pkg::GLYPH_COUNT-1];
   logic [9:0] pt_rd_ff;
   logic [8:0] hdr_rd_ff;

   // string latches
   logic [31:0]        pen_x_ff, baseline_y_ff;
   logic [SCALE_W-1:0] scale_ff;
   logic [7:0]         beam_ff;

   // per-character walk
   logic [SLOT_W-1:0]  slot_ff;
   logic [IDX_W-1:0]   idx_ff, last_idx_ff;
   logic [3:0]         adv_ff;
   logic [SEG_W-1:0]   seg_cnt_ff;
   logic               pen_up_ff;
   logic               pt_lift_ff;
   logic signed [PROD_W-1:0] prod_x_ff, prod_y_ff;
   logic [31:0]        prev_x_ff, prev_y_ff;

   // held segment
   logic               hold_valid_ff;
   logic [31:0]        hold_sx_ff, hold_sy_ff, hold_ex_ff, hold_ey_ff;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [31:0]        rsp_sx_ff, rsp_sy_ff, rsp_ex_ff, rsp_ey_ff;
   logic [7:0]         rsp_beam_ff;
   logic               rsp_last_ff;

   logic               load_hit;
   logic [SLOT_W-1:0]  load_slot;
   logic [CNT_W-1:0]   hdr_cnt, cnt_clamped;
   logic signed [PROD_W-1:0] hx_w, hy_w, sc_w;
   logic [31:0]        sx, sy;
   logic               out_free, new_seg, push_step, push_flush;
   logic [ADVP_W-1:0]  adv_prod;

   assign load_hit  = (req_char_code >= vstg_pkg::FIRST_CODE) &&
                      (req_char_code <= vstg_pkg::LOAD_LAST);
   assign load_slot = SLOT_W'(req_char_code - vstg_pkg::FIRST_CODE);

   assign hdr_cnt     = hdr_rd_ff[8:4];
   assign cnt_clamped = (int'(hdr_cnt) > vstg_pkg::MAX_POINTS) ?
                        CNT_W'(vstg_pkg::MAX_POINTS) : hdr_cnt;

   assign hx_w = PROD_W'($signed(pt_rd_ff[9:5]));
   assign hy_w = PROD_W'($signed(pt_rd_ff[4:0]));
   assign sc_w = $signed(PROD_W'(scale_ff));

   assign sx = pen_x_ff + 32'(prod_x_ff);
   assign sy = baseline_y_ff + 32'(prod_y_ff);

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign new_seg    = !pt_lift_ff && !pen_up_ff &&
                       (int'(seg_cnt_ff) < vstg_pkg::RESULT_LIMIT);
   assign push_step  = cmd.pt_step && new_seg && hold_valid_ff;
   assign push_flush = cmd.flush && hold_valid_ff;
   assign adv_prod   = ADVP_W'(adv_ff) * ADVP_W'(scale_ff);

   always_comb begin
      stat             = '0;
      stat.count_zero  = (hdr_cnt == '0);
      stat.last_point  = (idx_ff == last_idx_ff);
      stat.step_stall  = new_seg && hold_valid_ff && !out_free;
      stat.flush_stall = hold_valid_ff && !out_free;
   end

   // stores
   always_ff @(posedge clock) begin
      if (cmd.load_point && load_hit) begin
         point_mem[{load_slot, req_point_index}] <= {req_point_x, req_point_y};
      end
      if (cmd.load_header && load_hit) begin
         header_mem[load_slot] <= {req_glyph_points, req_glyph_advance};
      end
      if (cmd.hdr_read) hdr_rd_ff <= header_mem[slot_ff];
      if (cmd.pt_read)  pt_rd_ff  <= point_mem[{slot_ff, idx_ff}];
   end

   // string latches and pen advance
   always_ff @(posedge clock) begin
      if (reset) begin
         pen_x_ff      <= '0;
         baseline_y_ff <= '0;
         scale_ff      <= '0;
         beam_ff       <= '0;
      end else if (cmd.start_draw && req_new_string) begin
         pen_x_ff      <= 32'($signed(req_origin_x)) << vstg_pkg::POS_SHIFT;
         baseline_y_ff <= 32'($signed(req_origin_y)) << vstg_pkg::POS_SHIFT;
         scale_ff      <= SCALE_W'(req_size * vstg_pkg::SCALE_STEP);
         beam_ff       <= req_brightness;
      end else if (cmd.flush) begin
         pen_x_ff      <= pen_x_ff + 32'(adv_prod);
      end
   end

   // point walk
   always_ff @(posedge clock) begin
      if (cmd.start_draw) begin
         slot_ff    <= vstg_pkg::fold_slot(req_char_code);
         idx_ff     <= '0;
         seg_cnt_ff <= '0;
         pen_up_ff  <= 1'b1;
      end
      if (cmd.hdr_take) begin
         last_idx_ff <= IDX_W'(cnt_clamped - CNT_W'(1));
         adv_ff      <= hdr_rd_ff[3:0];
      end
      if (cmd.pt_mul) begin
         pt_lift_ff <= (pt_rd_ff == vstg_pkg::PEN_UP_CODE);
         prod_x_ff  <= hx_w * sc_w;
         prod_y_ff  <= hy_w * sc_w;
      end
      if (cmd.pt_step) begin
         idx_ff <= idx_ff + IDX_W'(1);
         if (pt_lift_ff) begin
            pen_up_ff <= 1'b1;
         end else begin
            pen_up_ff <= 1'b0;
            prev_x_ff <= sx;
            prev_y_ff <= sy;
            if (new_seg) begin
               seg_cnt_ff <= seg_cnt_ff + SEG_W'(1);
               hold_sx_ff <= prev_x_ff;
               hold_sy_ff <= prev_y_ff;
               hold_ex_ff <= sx;
               hold_ey_ff <= sy;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else if (cmd.pt_step && new_seg) begin
         hold_valid_ff <= 1'b1;
      end else if (cmd.flush) begin
         hold_valid_ff <= 1'b0;
      end
   end

   // output register: the held segment moves out once its successor is known
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (push_step || push_flush) rsp_valid_in = 1'b1;
      else if (rsp_ready)          rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_step || push_flush) begin
         rsp_sx_ff   <= hold_sx_ff;
         rsp_sy_ff   <= hold_sy_ff;
         rsp_ex_ff   <= hold_ex_ff;
         rsp_ey_ff   <= hold_ey_ff;
         rsp_beam_ff <= beam_ff;
         rsp_last_ff <= push_flush;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_start_x      = $signed(rsp_sx_ff);
   assign rsp_start_y      = $signed(rsp_sy_ff);
   assign rsp_end_x        = $signed(rsp_ex_ff);
   assign rsp_end_y        = $signed(rsp_ey_ff);
   assign rsp_beam_level   = rsp_beam_ff;
   assign rsp_last_segment = rsp_last_ff;

endmodule

`default_nettype wire

### rtl/core/vector_stroke_text_generator_unit.sv
// Top level: vector stroke text generator, controller plus datapath.
// Load beats leave ready high, so loads run back to back.
// A draw beat drops ready while it steps through its states:
//   header read and take, read / multiply / add per point, flush; the flush moves the last segment out.
// Output backpressure stretches a draw while the result register stays full.
// Reset clears pen, baseline, scale, brightness, controller state and valid flags; glyph stores are not cleared.
`default_nettype none

module vector_stroke_text_generator_unit (
   input  wire logic               clock,
   input  wire logic               reset,
   // request channel
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [1:0]         req_mode,
   input  wire logic               req_new_string,
   input  wire logic signed [7:0]  req_origin_x,
   input  wire logic signed [7:0]  req_origin_y,
   input  wire logic [7:0]         req_size,
   input  wire logic [7:0]         req_brightness,
   input  wire logic [7:0]         req_char_code,
   input  wire logic [3:0]         req_point_index,
   input  wire logic signed [4:0]  req_point_x,
   input  wire logic signed [4:0]  req_point_y,
   input  wire logic [4:0]         req_glyph_points,
   input  wire logic [3:0]         req_glyph_advance,
   // response channel, one beat per segment
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic signed [31:0]      rsp_start_x,
   output logic signed [31:0]      rsp_start_y,
   output logic signed [31:0]      rsp_end_x,
   output logic signed [31:0]      rsp_end_y,
   output logic [7:0]              rsp_beam_level,
   output logic                    rsp_last_segment
);

   // Controller and datapath talk only through cmd / stat.
   vstg_pkg::vstg_cmd_type  cmd;
   vstg_pkg::vstg_stat_type stat;

   // Controller: req_ready is high only between characters, so one beat is
   // in flight at a time; the output register lets the next beat enter while
   // the final segment of the previous character still waits.
   vstg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_mode),
      .req_ready (req_ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   // Datapath: one segment is held back so the last one of a character can
   // be flagged when the walk ends.
   vstg_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_new_string    (req_new_string),
      .req_origin_x      (req_origin_x),
      .req_origin_y      (req_origin_y),
      .req_size          (req_size),
      .req_brightness    (req_brightness),
      .req_char_code     (req_char_code),
      .req_point_index   (req_point_index),
      .req_point_x       (req_point_x),
      .req_point_y       (req_point_y),
      .req_glyph_points  (req_glyph_points),
      .req_glyph_advance (req_glyph_advance),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_start_x       (rsp_start_x),
      .rsp_start_y       (rsp_start_y),
      .rsp_end_x         (rsp_end_x),
      .rsp_end_y         (rsp_end_y),
      .rsp_beam_level    (rsp_beam_level),
      .rsp_last_segment  (rsp_last_segment)
   );

endmodule

`default_nettype wire

### verif/tb_vector_stroke_text_generator_unit.sv
// Testbench for the vector stroke text generator: directed table, random strings, segment checks.
`timescale 1ns / 100ps

module tb_vector_stroke_text_generator_unit;

   // Mode code that the block leaves alone.
   localparam logic [1:0] MODE_NONE = 2'd3;

   // Characters used by the directed table.
   localparam logic [7:0] CH_I       = 8'h49;
   localparam logic [7:0] CH_I_LOWER = 8'h69;

   // Total request beats, directed rows plus random part.
   localparam int ITEMS       = 110;
   // Trailing wait; covers the longest draw with margin.
   localparam int TAIL_CYCLES = 64;

   // One request beat, field by field.
   typedef struct packed {
      logic [1:0] mode;
      logic       new_string;
      logic [7:0] origin_x;
      logic [7:0] origin_y;
      logic [7:0] size;
      logic [7:0] brightness;
      logic [7:0] char_code;
      logic [3:0] point_index;
      logic [4:0] point_x;
      logic [4:0] point_y;
      logic [4:0] glyph_points;
      logic [3:0] glyph_advance;
   } req_item_type;

   localparam int REQ_W = $bits(req_item_type);

   // One beam segment as the response channel carries it.
   typedef struct packed {
      logic [31:0] sx;
      logic [31:0] sy;
      logic [31:0] ex;
      logic [31:0] ey;
      logic [7:0]  beam;
      logic        last;
   } seg_type;

   // Directed row: beat, plus a hand-computed segment where one is given.
   typedef struct packed {
      req_item_type beat;
      bit           typed;
      seg_type      seg;
   } stim_row_type;

   // ---------------------------------------------------------------------
   // Clock, reset and DUT hookup
   // ---------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   logic              req_valid         = 1'b0;
   logic              req_ready;
   logic [1:0]        req_mode          = '0;
   logic              req_new_string    = 1'b0;
   logic signed [7:0] req_origin_x      = '0;
   logic signed [7:0] req_origin_y      = '0;
   logic [7:0]        req_size          = '0;
   logic [7:0]        req_brightness    = '0;
   logic [7:0]        req_char_code     = '0;
   logic [3:0]        req_point_index   = '0;
   logic signed [4:0] req_point_x       = '0;
   logic signed [4:0] req_point_y       = '0;
   logic [4:0]        req_glyph_points  = '0;
   logic [3:0]        req_glyph_advance = '0;

   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [31:0] rsp_start_x;
   logic signed [31:0] rsp_start_y;
   logic signed [31:0] rsp_end_x;
   logic signed [31:0] rsp_end_y;
   logic [7:0]         rsp_beam_level;
   logic               rsp_last_segment;

   vector_stroke_text_generator_unit u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_mode          (req_mode),
      .req_new_string    (req_new_string),
      .req_origin_x      (req_origin_x),
      .req_origin_y      (req_origin_y),
      .req_size          (req_size),
      .req_brightness    (req_brightness),
      .req_char_code     (req_char_code),
      .req_point_index   (req_point_index),
      .req_point_x       (req_point_x),
      .req_point_y       (req_point_y),
      .req_glyph_points  (req_glyph_points),
      .req_glyph_advance (req_glyph_advance),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_start_x       (rsp_start_x),
      .rsp_start_y       (rsp_start_y),
      .rsp_end_x         (rsp_end_x),
      .rsp_end_y         (rsp_end_y),
      .rsp_beam_level    (rsp_beam_level),
      .rsp_last_segment  (rsp_last_segment)
   );

   // ---------------------------------------------------------------------
   // Predictor state: glyph tables, pen, baseline, scale, brightness.
   // The seen masks track which table entries hold data, so stimulus never
   // draws a glyph whose header or points were not loaded.
   // ---------------------------------------------------------------------
   logic [9:0]  glyph_pts [vstg_pkg::GLYPH_COUNT*vstg_pkg::MAX_POINTS];
   logic [8:0]  glyph_hdr [vstg_pkg::GLYPH_COUNT];
   bit [vstg_pkg::MAX_POINTS-1:0] pt_seen [vstg_pkg::GLYPH_COUNT];
   bit          hdr_seen  [vstg_pkg::GLYPH_COUNT];
   logic [31:0] pen_pos      = '0;
   logic [31:0] base_y       = '0;
   logic [31:0] stroke_scale = '0;
   logic [7:0]  beam_reg     = '0;

   seg_type stroke_q[$];     // segments still owed by the DUT, oldest first
   seg_type stroke_new[$];   // segments produced by the beat just accepted
   int      loaded_q[$];     // glyph slots that were loaded at least once

   int      err_count  = 0;
   int      beats_sent = 0;
   int      burst_left = 0;
   seg_type want_seg;

   // Draw code to table slot: lower case folds up, unprintables become space.
   function automatic int glyph_slot(input logic [7:0] code);
      logic [7:0] c;
      c = code;
      if (c >= vstg_pkg::LOWER_A && c <= vstg_pkg::LOWER_Z) c = c - vstg_pkg::CASE_OFFSET;
      if (c < vstg_pkg::FIRST_CODE || c > vstg_pkg::LAST_CODE) c = vstg_pkg::FIRST_CODE;
      if (int'(c - vstg_pkg::FIRST_CODE) >= vstg_pkg::GLYPH_COUNT) return 0;
      return int'(c - vstg_pkg::FIRST_CODE);
   endfunction

   function automatic int clip_count(input int slot);
      int cnt;
      cnt = int'(glyph_hdr[slot][8:4]);
      return (cnt > vstg_pkg::MAX_POINTS) ? vstg_pkg::MAX_POINTS : cnt;
   endfunction

   // True when a draw of this slot reads only loaded entries.
   function automatic bit glyph_ready(input int slot);
      int i;
      if (!hdr_seen[slot]) return 1'b0;
      for (i = 0; i < clip_count(slot); i++)
         if (!pt_seen[slot][i]) return 1'b0;
      return 1'b1;
   endfunction

   // Applies one accepted beat to the predictor; segments go to stroke_new.
   function automatic void trace_strokes(input req_item_type it);
      int          slot, cnt, i, nseg;
      logic [9:0]  pt;
      logic [31:0] cx, cy, px, py;
      bit          lifted, held_ok;
      seg_type     held;
      stroke_new.delete();
      px = '0;
      py = '0;
      lifted = 1'b1;
      held_ok = 1'b0;
      nseg = 0;
      if (it.mode == vstg_pkg::MODE_POINT || it.mode == vstg_pkg::MODE_HEADER) begin
         // loads use the raw code, no folding; out-of-table codes drop
         if (it.char_code < vstg_pkg::FIRST_CODE || it.char_code > vstg_pkg::LOAD_LAST) return;
         slot = int'(it.char_code - vstg_pkg::FIRST_CODE);
         if (it.mode == vstg_pkg::MODE_POINT) begin
            glyph_pts[slot*vstg_pkg::MAX_POINTS + it.point_index] = {it.point_x, it.point_y};
            pt_seen[slot][it.point_index] = 1'b1;
         end else begin
            glyph_hdr[slot] = {it.glyph_points, it.glyph_advance};
            hdr_seen[slot] = 1'b1;
         end
         return;
      end
      if (it.mode != vstg_pkg::MODE_DRAW) return;
      if (it.new_string) begin
         pen_pos      = {{24{it.origin_x[7]}}, it.origin_x} * 32'(vstg_pkg::POS_SCALE);
         base_y       = {{24{it.origin_y[7]}}, it.origin_y} * 32'(vstg_pkg::POS_SCALE);
         stroke_scale = {24'd0, it.size} * 32'(vstg_pkg::SCALE_STEP);
         beam_reg     = it.brightness;
      end
      slot = glyph_slot(it.char_code);
      cnt  = clip_count(slot);
      for (i = 0; i < cnt; i++) begin
         pt = glyph_pts[slot*vstg_pkg::MAX_POINTS + i];
         if (pt == vstg_pkg::PEN_UP_CODE) begin
            lifted = 1'b1;
            continue;
         end
         cx = pen_pos + {{27{pt[9]}}, pt[9:5]} * stroke_scale;
         cy = base_y  + {{27{pt[4]}}, pt[4:0]} * stroke_scale;
         if (!lifted && nseg < vstg_pkg::RESULT_LIMIT) begin
            // hold one back so the final one can carry the last flag
            if (held_ok) stroke_new.push_back(held);
            held = '{sx: px, sy: py, ex: cx, ey: cy, beam: beam_reg, last: 1'b0};
            held_ok = 1'b1;
            nseg++;
         end
         lifted = 1'b0;
         px = cx;
         py = cy;
      end
      if (held_ok) begin
         held.last = 1'b1;
         stroke_new.push_back(held);
      end
      pen_pos = pen_pos + {28'd0, glyph_hdr[slot][3:0]} * stroke_scale;
   endfunction

   // ---------------------------------------------------------------------
   // Beat builders. Fields a mode ignores are left random.
   // ---------------------------------------------------------------------
   function automatic req_item_type rand_base();
      req_item_type it;
      it = req_item_type'(REQ_W'({$urandom, $urandom, $urandom}));
      return it;
   endfunction

   function automatic req_item_type mk_point(input logic [7:0] code, input int idx,
                                             input int x, input int y);
      req_item_type it;
      it = rand_base();
      it.mode        = vstg_pkg::MODE_POINT;
      it.char_code   = code;
      it.point_index = 4'(idx);
      it.point_x     = 5'(x);
      it.point_y     = 5'(y);
      return it;
   endfunction

   function automatic req_item_type mk_header(input logic [7:0] code, input int cnt,
                                              input int adv);
      req_item_type it;
      it = rand_base();
      it.mode          = vstg_pkg::MODE_HEADER;
      it.char_code     = code;
      it.glyph_points  = 5'(cnt);
      it.glyph_advance = 4'(adv);
      return it;
   endfunction

   function automatic req_item_type mk_draw(input bit ns, input int ox, input int oy,
                                            input int sz, input int br,
                                            input logic [7:0] code);
      req_item_type it;
      it = rand_base();
      it.mode       = vstg_pkg::MODE_DRAW;
      it.new_string = ns;
      it.origin_x   = 8'(ox);
      it.origin_y   = 8'(oy);
      it.size       = 8'(sz);
      it.brightness = 8'(br);
      it.char_code  = code;
      return it;
   endfunction

   // Hand-computed single segment (always the last of its character).
   function automatic seg_type mk_seg(input int sx, input int sy, input int ex,
                                      input int ey, input int beam);
      return '{sx: 32'(sx), sy: 32'(sy), ex: 32'(ex), ey: 32'(ey),
               beam: 8'(beam), last: 1'b1};
   endfunction

   function automatic stim_row_type plain(input req_item_type it);
      return '{beat: it, typed: 1'b0, seg: '0};
   endfunction

   function automatic stim_row_type with_seg(input req_item_type it, input seg_type s);
      return '{beat: it, typed: 1'b1, seg: s};
   endfunction

   // Picks a draw code whose glyph is fully loaded; mostly loaded glyphs,
   // sometimes lower case, now and then an unprintable code (space glyph).
   function automatic logic [7:0] pick_code();
      logic [7:0] c;
      int         t;
      for (t = 0; t < 8; t++) begin
         if ($urandom_range(0, 7) == 0 || loaded_q.size() == 0) begin
            c = $urandom_range(0, 1) ? 8'($urandom_range(0, 31))
                                     : 8'($urandom_range(127, 255));
         end else begin
            c = 8'(loaded_q[$urandom_range(0, loaded_q.size() - 1)]) + vstg_pkg::FIRST_CODE;
            if (c >= vstg_pkg::LOWER_A - vstg_pkg::CASE_OFFSET &&
                c <= vstg_pkg::LOWER_Z - vstg_pkg::CASE_OFFSET &&
                $urandom_range(0, 1) == 1)
               c = c + vstg_pkg::CASE_OFFSET;
         end
         if (glyph_ready(glyph_slot(c))) return c;
      end
      return vstg_pkg::FIRST_CODE;
   endfunction

   // ---------------------------------------------------------------------
   // Request driver. Bursts of random length, random idle gaps between.
   // Valid is only dropped at the start of a gap, so it never gets two
   // nonblocking writes in the same step.
   // ---------------------------------------------------------------------
   task automatic send_beat(input req_item_type it, input bit typed, input seg_type s);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid         <= 1'b1;
      req_mode          <= it.mode;
      req_new_string    <= it.new_string;
      req_origin_x      <= it.origin_x;
      req_origin_y      <= it.origin_y;
      req_size          <= it.size;
      req_brightness    <= it.brightness;
      req_char_code     <= it.char_code;
      req_point_index   <= it.point_index;
      req_point_x       <= it.point_x;
      req_point_y       <= it.point_y;
      req_glyph_points  <= it.glyph_points;
      req_glyph_advance <= it.glyph_advance;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      // accepted at this edge
      trace_strokes(it);
      if (typed) begin
         stroke_q.push_back(s);
      end else begin
         while (stroke_new.size() != 0) stroke_q.push_back(stroke_new.pop_front());
      end
      beats_sent++;
   endtask

   // Loads a glyph header and every point that its count covers.
   task automatic load_glyph(input int slot, input int cnt, input int lift_pct);
      int i;
      logic [7:0] code;
      code = 8'(slot) + vstg_pkg::FIRST_CODE;
      send_beat(mk_header(code, cnt, $urandom_range(0, 15)), 1'b0, '0);
      for (i = 0; i < ((cnt > vstg_pkg::MAX_POINTS) ? vstg_pkg::MAX_POINTS : cnt); i++) begin
         if ($urandom_range(0, 99) < lift_pct)
            send_beat(mk_point(code, i, -1, -1), 1'b0, '0);
         else
            send_beat(mk_point(code, i, $urandom_range(0, 31), $urandom_range(0, 31)),
                      1'b0, '0);
      end
      loaded_q.push_back(slot);
   endtask

   // A string: first character latches origin, size and brightness.
   task automatic draw_string(input int len);
      int n;
      for (n = 0; n < len; n++)
         send_beat(mk_draw(n == 0 || $urandom_range(0, 9) == 0, $urandom, $urandom,
                           $urandom, $urandom, pick_code()), 1'b0, '0);
   endtask

   // ---------------------------------------------------------------------
   // Response side: stall pattern of its own, switching between always
   // ready, a fixed rotating pattern and random draws, ready three times in four.
   // ---------------------------------------------------------------------
   int          sink_mode = 0;
   int          sink_left = 0;
   logic [11:0] stall_pat = 12'b1101_1100_1011;

   always @(posedge clock) begin
      if (sink_left == 0) begin
         sink_mode <= $urandom_range(0, 2);
         sink_left <= $urandom_range(20, 80);
      end else begin
         sink_left <= sink_left - 1;
      end
      case (sink_mode)
         0: begin
            rsp_ready <= 1'b1;
         end
         1: begin
            rsp_ready <= stall_pat[0];
            stall_pat <= {stall_pat[0], stall_pat[11:1]};
         end
         default: begin
            rsp_ready <= ($urandom_range(0, 3) != 0);
         end
      endcase
   end

   task automatic report_err(input string what, input logic [31:0] got,
                             input logic [31:0] want);
      $display("%0t: mismatch on %s: got %0d, want %0d", $time, what,
               $signed(got), $signed(want));
      err_count++;
   endtask

   // Every accepted segment is checked against the oldest one owed.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (stroke_q.size() == 0) begin
            report_err("segment with none pending (start_x)", rsp_start_x, '0);
         end else begin
            want_seg = stroke_q.pop_front();
            if (rsp_start_x !== want_seg.sx) report_err("start_x", rsp_start_x, want_seg.sx);
            if (rsp_start_y !== want_seg.sy) report_err("start_y", rsp_start_y, want_seg.sy);
            if (rsp_end_x !== want_seg.ex) report_err("end_x", rsp_end_x, want_seg.ex);
            if (rsp_end_y !== want_seg.ey) report_err("end_y", rsp_end_y, want_seg.ey);
            if (rsp_beam_level !== want_seg.beam)
               report_err("beam_level", 32'(rsp_beam_level), 32'(want_seg.beam));
            if (rsp_last_segment !== want_seg.last)
               report_err("last_segment", 32'(rsp_last_segment), 32'(want_seg.last));
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   initial begin
      stim_row_type dir_rows[$];
      req_item_type it;
      int           k, next_drain, cnt;

      // Space glyph first: unprintable and out-of-table codes all draw it.
      dir_rows.push_back(plain(mk_header(vstg_pkg::FIRST_CODE, 0, 5)));
      // 'I': one vertical stroke, two points.
      dir_rows.push_back(plain(mk_header(CH_I, 2, 3)));
      dir_rows.push_back(plain(mk_point(CH_I, 0, 0, 0)));
      dir_rows.push_back(plain(mk_point(CH_I, 1, 0, 2)));
      // Straight out of reset: pen, baseline, scale and brightness are zero,
      // so the stroke collapses onto the origin.
      dir_rows.push_back(with_seg(mk_draw(1'b0, 0, 0, 0, 0, CH_I), mk_seg(0, 0, 0, 0, 0)));
      // Most negative x origin, top baseline, largest size and brightness:
      // pen -16384, baseline 16256, scale 255*21 = 5355.
      dir_rows.push_back(with_seg(mk_draw(1'b1, -128, 127, 255, 255, CH_I),
                                  mk_seg(-16384, 16256, -16384, 26966, 255)));
      // Lower case folds onto the capital; pen has advanced by 3*5355.
      dir_rows.push_back(plain(mk_draw(1'b0, 0, 0, 0, 0, CH_I_LOWER)));
      // Unprintables draw the empty space glyph: no segments; the pen advance (zero at size 0) still applies.
      dir_rows.push_back(plain(mk_draw(1'b1, 127, -128, 0, 0, 8'h00)));
      dir_rows.push_back(plain(mk_draw(1'b0, 0, 0, 0, 0, 8'hFF)));
      dir_rows.push_back(plain(mk_draw(1'b1, 5, 5, 9, 77, 8'h7F)));
      // Unused mode: nothing happens.
      it = mk_draw(1'b1, 3, 3, 3, 3, CH_I);
      it.mode = MODE_NONE;
      dir_rows.push_back(plain(it));
      // Loads outside the glyph table are dropped.
      dir_rows.push_back(plain(mk_header(8'h1F, 31, 15)));
      dir_rows.push_back(plain(mk_point(8'h7F, 15, -16, 15)));
      dir_rows.push_back(plain(mk_point(8'hFF, 15, 15, -16)));
      // '~' is the last table slot: corner points and a pen lift in between.
      dir_rows.push_back(plain(mk_header(vstg_pkg::LAST_CODE, 4, 15)));
      dir_rows.push_back(plain(mk_point(vstg_pkg::LAST_CODE, 0, -16, -16)));
      dir_rows.push_back(plain(mk_point(vstg_pkg::LAST_CODE, 1, -1, -1)));
      dir_rows.push_back(plain(mk_point(vstg_pkg::LAST_CODE, 2, 15, 15)));
      dir_rows.push_back(plain(mk_point(vstg_pkg::LAST_CODE, 3, 15, -16)));
      // Origin (1,1), scale 21: only the segment after the lift is drawn,
      // (128+315, 128+315) to (128+315, 128-336).
      dir_rows.push_back(with_seg(mk_draw(1'b1, 1, 1, 1, 1, vstg_pkg::LAST_CODE),
                                  mk_seg(443, 443, 443, -208, 1)));
      dir_rows.push_back(plain(mk_draw(1'b0, 0, 0, 0, 0, vstg_pkg::LAST_CODE)));
      dir_rows.push_back(plain(mk_draw(1'b1, -37, 90, 200, 128, CH_I)));

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[r])
         send_beat(dir_rows[r].beat, dir_rows[r].typed, dir_rows[r].seg);
      loaded_q.push_back(0);
      loaded_q.push_back(int'(CH_I - vstg_pkg::FIRST_CODE));
      loaded_q.push_back(int'(vstg_pkg::LAST_CODE - vstg_pkg::FIRST_CODE));

      // Random part. Open with a header count above the point limit and a
      // full 16-point glyph with no lifts (15 segments, the segment cap).
      load_glyph($urandom_range(1, 64), $urandom_range(vstg_pkg::MAX_POINTS + 1, 31), 10);
      draw_string(3);
      load_glyph($urandom_range(1, 64), vstg_pkg::MAX_POINTS, 0);
      loaded_q.push_back(loaded_q[$]);
      draw_string(4);
      // first pause lands well before the last beat
      next_drain = beats_sent + 20;

      while (beats_sent < ITEMS) begin
         // Now and then hold the request side until the DUT has drained.
         if (beats_sent >= next_drain) begin
            req_valid <= 1'b0;
            burst_left = 0;
            @(posedge clock);
            while (stroke_q.size() != 0) @(posedge clock);
            next_drain = beats_sent + 40;
         end
         k = $urandom_range(0, 99);
         if (k < 30) begin
            k = $urandom_range(0, 9);
            cnt = (k < 7) ? $urandom_range(0, 8)
                : (k < 8) ? vstg_pkg::MAX_POINTS
                : $urandom_range(vstg_pkg::MAX_POINTS + 1, 31);
            load_glyph($urandom_range(0, vstg_pkg::GLYPH_COUNT - 1), cnt, 15);
         end else if (k < 88) begin
            draw_string($urandom_range(1, 6));
         end else begin
            // Noise the block ignores: unused mode or loads outside the table.
            it = rand_base();
            if ($urandom_range(0, 1) == 0) begin
               it.mode = MODE_NONE;
            end else begin
               it.mode = $urandom_range(0, 1) ? vstg_pkg::MODE_POINT : vstg_pkg::MODE_HEADER;
               it.char_code = $urandom_range(0, 1) ? 8'($urandom_range(0, 31))
                                                   : 8'($urandom_range(127, 255));
            end
            send_beat(it, 1'b0, '0);
         end
      end

      // All beats in; wait for every owed segment, then let the pipe settle.
      req_valid <= 1'b0;
      while (stroke_q.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (err_count == 0 && stroke_q.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // Watchdog: fails the run far beyond the slowest legal run.
   initial begin
      #8_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
